FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL that carries checks.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLSQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dlsq_pkg.sv
// ----------------------------------------------------------------------------
// dlsq_pkg
// Types and constants shared by the delta-list sleep queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dlsq_pkg;

  localparam int DELTA_W = 29;
  localparam int PID_W   = 8;
  localparam int MS_W    = 32;

  // Division by the 10 ms tick period: floor(ms * 0xCCCCCCCD / 2^35) is exact
  // for every 32-bit value.
  localparam logic [MS_W-1:0] TICK_RECIP = 32'hCCCC_CCCD;
  localparam int              TICK_SHIFT = 35;

  localparam logic OP_SLEEP    = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_READY  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_INS_HEAD,
    ST_WALK,
    ST_NEW_WR,
    ST_FIN,
    ST_FIN_CUR,
    ST_FIN_SUCC,
    ST_TICK_CHK,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_HEAD_SUB,
    WR_HEAD_DEC,
    WR_NEW,
    WR_CUR,
    WR_SUCC
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_IMM,
    RES_FULL,
    RES_REL
  } res_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     ld_ticks;
    logic     rd_en;
    logic     rd_next;
    logic     alloc;
    wr_sel_t  wr_sel;
    logic     front_ins;
    logic     first_ins;
    logic     head_pass;
    logic     walk_step;
    logic     walk_break;
    logic     tail_ins;
    logic     release_head;
    logic     ld_res;
    res_sel_t res_sel;
    logic     out_load;
  } dlsq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic ms_zero;
    logic full;
    logic nonempty;
    logic ticks_lt;
    logic delta_zero;
    logic head_is_tail;
    logic link_is_tail;
    logic has_succ;
    logic out_free;
  } dlsq_sts_t;

endpackage

`default_nettype wire

FILE: design/dlsq_if.sv
// ----------------------------------------------------------------------------
// dlsq_if
// Valid/ready channel interfaces for sleep queue requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlsq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  proc_id;
  logic [31:0] time_ms;

  modport source (output valid, output op, output proc_id, output time_ms, input ready);
  modport sink   (input valid, input op, input proc_id, input time_ms, output ready);
endinterface

interface dlsq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ready_id;

  modport source (output valid, output kind, output ready_id, input ready);
  modport sink   (input valid, input kind, input ready_id, output ready);
endinterface

`default_nettype wire

FILE: design/delta_list_sleep_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_core
// Sleep queue kept as a delta list, driven by sleep requests and timer ticks.
// ----------------------------------------------------------------------------
// Each request transaction is either a sleep request (op = 0) or one timer
// tick (op = 1). A sleep of time_ms milliseconds waits time_ms / 10 ticks;
// a request of 0 ms is answered at once with kind 0, and a nonzero request
// that finds all MAX_SLEEPERS entries in use is answered with kind 1, both
// carrying the requester's proc_id. Otherwise the process is linked into a
// list whose entries hold their wait relative to the entry before them,
// behind any entries that wake at the same tick. A tick decrements the head
// entry, or releases it (one result transaction, kind 0) when its wait has
// run out. The block takes one request at a time. An inserted sleep walks
// the list from the head past every entry that wakes no later than it, and
// the walk is bound by the single read port of the entry memory, one entry
// per cycle. A finished result sits in an output register, and a new
// request is accepted while it waits there; the block only stalls when a
// second result is ready before the first one has been taken. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module delta_list_sleep_queue_core #(
  parameter int MAX_SLEEPERS = 32
) (
  input  wire        clk,
  input  wire        rst,
  dlsq_in_if.sink    in_ch,
  dlsq_out_if.source out_ch
);
  import dlsq_pkg::*;

  // Command and status between the sequencer and the datapath.
  dlsq_cmd_t cmd;
  dlsq_sts_t sts;

  dlsq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  dlsq_dp #(
    .MAX_SLEEPERS (MAX_SLEEPERS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // One request at a time: the block is busy right after taking a transaction.
  `DLSQ_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "double accept")
  // A result must never overwrite one that has not been taken.
  `DLSQ_ASSERT_SAME(a_load_when_free, cmd.out_load, sts.out_free, "output register overwritten")
  // A release only happens on a nonempty list.
  `DLSQ_ASSERT_SAME(a_release_nonempty, cmd.release_head, sts.nonempty, "release from empty list")
  // A slot is only allocated when the store has room.
  `DLSQ_ASSERT_SAME(a_alloc_not_full, cmd.alloc, !sts.full, "allocation into full store")

endmodule

`default_nettype wire

FILE: design/dlsq_ctrl.sv
// ----------------------------------------------------------------------------
// dlsq_ctrl
// Sequencer for the sleep queue: decodes requests, walks the list, emits.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsq_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire dlsq_pkg::dlsq_sts_t sts,
  output dlsq_pkg::dlsq_cmd_t      cmd
);
  import dlsq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.ld_ticks = 1'b1;
        if (sts.op == OP_SLEEP) begin
          if (sts.ms_zero) begin
            cmd.ld_res  = 1'b1;
            cmd.res_sel = RES_IMM;
            state_next  = ST_EMIT;
          end else if (sts.full) begin
            cmd.ld_res  = 1'b1;
            cmd.res_sel = RES_FULL;
            state_next  = ST_EMIT;
          end else begin
            state_next = ST_ALLOC;
          end
        end else if (sts.nonempty) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_TICK_CHK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        if (sts.nonempty) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_INS_HEAD;
        end else begin
          state_next = ST_NEW_WR;
        end
      end
      ST_NEW_WR: begin
        cmd.wr_sel    = WR_NEW;
        cmd.first_ins = !sts.nonempty;
        state_next    = ST_IDLE;
      end
      ST_INS_HEAD: begin
        if (sts.ticks_lt) begin
          cmd.wr_sel    = WR_HEAD_SUB;
          cmd.front_ins = 1'b1;
          state_next    = ST_NEW_WR;
        end else begin
          cmd.head_pass = 1'b1;
          if (sts.head_is_tail) begin
            state_next = ST_FIN;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
            state_next  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (sts.ticks_lt) begin
          cmd.walk_break = 1'b1;
          state_next     = ST_FIN;
        end else begin
          cmd.walk_step = 1'b1;
          if (sts.link_is_tail) begin
            state_next = ST_FIN;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
            state_next  = ST_WALK;
          end
        end
      end
      ST_FIN: begin
        cmd.wr_sel = WR_NEW;
        state_next = ST_FIN_CUR;
      end
      ST_FIN_CUR: begin
        cmd.wr_sel = WR_CUR;
        if (sts.has_succ) begin
          state_next = ST_FIN_SUCC;
        end else begin
          cmd.tail_ins = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FIN_SUCC: begin
        cmd.wr_sel = WR_SUCC;
        state_next = ST_IDLE;
      end
      ST_TICK_CHK: begin
        if (!sts.delta_zero) begin
          cmd.wr_sel = WR_HEAD_DEC;
          state_next = ST_IDLE;
        end else begin
          cmd.release_head = 1'b1;
          cmd.ld_res       = 1'b1;
          cmd.res_sel      = RES_REL;
          state_next       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dlsq_dp.sv
// ----------------------------------------------------------------------------
// dlsq_dp
// Datapath of the sleep queue: entry memories, free-slot stack, list
// pointers, walk registers, tick conversion and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsq_dp #(
  parameter int MAX_SLEEPERS = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  dlsq_in_if.sink                  in_ch,
  dlsq_out_if.source               out_ch,
  input  wire dlsq_pkg::dlsq_cmd_t cmd,
  output dlsq_pkg::dlsq_sts_t      sts
);
  import dlsq_pkg::*;

  localparam int IW = $clog2(MAX_SLEEPERS);
  localparam int CW = $clog2(MAX_SLEEPERS + 1);

  // Entry store; contents are meaningful only for slots on the list.
  logic [DELTA_W-1:0] rec_delta [MAX_SLEEPERS];
  logic [IW-1:0]      rec_link  [MAX_SLEEPERS];
  logic [PID_W-1:0]   pid_mem   [MAX_SLEEPERS];
  logic [IW-1:0]      stack_mem [MAX_SLEEPERS];

  logic               op_q;
  logic [PID_W-1:0]   pid_q;
  logic [MS_W-1:0]    ms_q;
  logic [DELTA_W-1:0] ticks;
  logic [2*MS_W-1:0]  prod;

  logic [IW-1:0]      head, tail;
  logic               nonempty;
  logic [CW-1:0]      count, fresh, sp;
  logic [IW-1:0]      stack_top, top_idx, slot_sel, new_slot;

  logic [IW-1:0]      cur, cur_link, nx, nx_link;
  logic [DELTA_W-1:0] cur_delta, nx_delta;
  logic               has_succ;

  logic [DELTA_W-1:0] rd_delta;
  logic [IW-1:0]      rd_link, rd_addr;
  logic [PID_W-1:0]   rd_pid;

  logic               wr_en;
  logic [IW-1:0]      wr_addr, wr_link;
  logic [DELTA_W-1:0] wr_delta;

  logic               res_kind, out_valid, out_kind;
  logic [PID_W-1:0]   res_id, out_id;

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_q  <= in_ch.op;
      pid_q <= in_ch.proc_id;
      ms_q  <= in_ch.time_ms;
    end
  end

  assign prod = {{MS_W{1'b0}}, ms_q} * {{MS_W{1'b0}}, TICK_RECIP};

  // Remaining wait of the new entry relative to the current walk position.
  always_ff @(posedge clk) begin
    if (cmd.ld_ticks) begin
      ticks <= prod[TICK_SHIFT +: DELTA_W];
    end else if (cmd.head_pass || cmd.walk_step) begin
      ticks <= ticks - rd_delta;
    end
  end

  // Free-slot stack: released slots are pushed, fresh slots come from a fill count.
  assign top_idx  = (sp == '0) ? '0 : IW'(sp - CW'(1));
  assign slot_sel = (sp != '0) ? stack_top : fresh[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.release_head) begin
      stack_mem[sp[IW-1:0]] <= head;
    end
    stack_top <= stack_mem[top_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      pid_mem[slot_sel] <= pid_q;
      new_slot          <= slot_sel;
    end
  end

  // List head, tail and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
      count    <= '0;
      fresh    <= '0;
      sp       <= '0;
    end else begin
      if (cmd.alloc) begin
        count <= count + CW'(1);
        if (sp != '0) begin
          sp <= sp - CW'(1);
        end else begin
          fresh <= fresh + CW'(1);
        end
      end
      if (cmd.first_ins) begin
        head     <= new_slot;
        tail     <= new_slot;
        nonempty <= 1'b1;
      end
      if (cmd.front_ins) begin
        head <= new_slot;
      end
      if (cmd.tail_ins) begin
        tail <= new_slot;
      end
      if (cmd.release_head) begin
        head  <= rd_link;
        count <= count - CW'(1);
        sp    <= sp + CW'(1);
        if (head == tail) begin
          nonempty <= 1'b0;
        end
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_succ <= 1'b0;
    end else if (cmd.head_pass) begin
      has_succ <= 1'b0;
    end else if (cmd.walk_break) begin
      has_succ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_pass) begin
      cur       <= head;
      cur_delta <= rd_delta;
      cur_link  <= rd_link;
    end else if (cmd.walk_step) begin
      cur       <= cur_link;
      cur_delta <= rd_delta;
      cur_link  <= rd_link;
    end
    if (cmd.walk_break) begin
      nx       <= cur_link;
      nx_delta <= rd_delta;
      nx_link  <= rd_link;
    end else if (cmd.front_ins) begin
      nx <= head;
    end
  end

  // Entry store access: one registered read and one write per cycle.
  assign rd_addr = cmd.rd_next ? rd_link : head;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_delta <= rec_delta[rd_addr];
      rd_link  <= rec_link[rd_addr];
      rd_pid   <= pid_mem[head];
    end
  end

  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = head;
    wr_link  = rd_link;
    wr_delta = rd_delta;
    case (cmd.wr_sel)
      WR_HEAD_SUB: begin
        wr_delta = rd_delta - ticks;
      end
      WR_HEAD_DEC: begin
        wr_delta = rd_delta - DELTA_W'(1);
      end
      WR_NEW: begin
        wr_addr  = new_slot;
        wr_link  = nx;
        wr_delta = ticks;
      end
      WR_CUR: begin
        wr_addr  = cur;
        wr_link  = new_slot;
        wr_delta = cur_delta;
      end
      WR_SUCC: begin
        wr_addr  = nx;
        wr_link  = nx_link;
        wr_delta = nx_delta - ticks;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_delta[wr_addr] <= wr_delta;
      rec_link[wr_addr]  <= wr_link;
    end
  end

  // Result staging and output register.
  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      case (cmd.res_sel)
        RES_IMM: begin
          res_kind <= KIND_READY;
          res_id   <= pid_q;
        end
        RES_FULL: begin
          res_kind <= KIND_REJECT;
          res_id   <= pid_q;
        end
        RES_REL: begin
          res_kind <= KIND_READY;
          res_id   <= rd_pid;
        end
        default: begin
          res_kind <= KIND_READY;
          res_id   <= pid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= res_kind;
      out_id   <= res_id;
    end
  end

  assign in_ch.ready     = cmd.in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = out_kind;
  assign out_ch.ready_id = out_id;

  assign sts.in_valid     = in_ch.valid;
  assign sts.op           = op_q;
  assign sts.ms_zero      = (ms_q == '0);
  assign sts.full         = (count == CW'(MAX_SLEEPERS));
  assign sts.nonempty     = nonempty;
  assign sts.ticks_lt     = (ticks < rd_delta);
  assign sts.delta_zero   = (rd_delta == '0);
  assign sts.head_is_tail = (head == tail);
  assign sts.link_is_tail = (cur_link == tail);
  assign sts.has_succ     = has_succ;
  assign sts.out_free     = !out_valid || out_ch.ready;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta-list sleep queue core.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and offered by a clocked driver.
// A scoreboard predicts every wake-up and rejection from an independent
// software copy of the sleep list and checks the result channel in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import dlsq_pkg::*;

  localparam int SLOTS          = 32;
  localparam int PHASE_ITEMS    = 340;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT    = 100000;
  // Worst case per request is a full list walk plus result back-pressure;
  // the limit below leaves well over ten times the expected run length.
  localparam int LIMIT_CYCLES   = 1500000;

  // One request transaction as it travels on the input channel.
  typedef struct packed {
    logic             op;
    logic [PID_W-1:0] pid;
    logic [MS_W-1:0]  ms;
  } sleep_req_t;

  // One result transaction: a wake-up or a rejection.
  typedef struct packed {
    logic             kind;
    logic [PID_W-1:0] id;
  } wake_res_t;

  logic clk;
  logic rst;

  dlsq_in_if  req_ch();
  dlsq_out_if wake_ch();

  delta_list_sleep_queue_core #(
    .MAX_SLEEPERS(SLOTS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (req_ch),
    .out_ch(wake_ch)
  );

  // Requests waiting to be offered, and results the block still owes us.
  sleep_req_t req_backlog[$];
  wake_res_t  wake_expect[$];
  sleep_req_t req_next;

  // Shadow copy of the sleep list. Deltas are relative to the previous entry,
  // and the head's delta is relative to the current tick.
  logic [PID_W-1:0]   sq_pid   [SLOTS];
  logic [DELTA_W-1:0] sq_delta [SLOTS];
  int                 sq_next  [SLOTS];
  bit                 sq_used  [SLOTS];
  bit                 sq_tail  [SLOTS];
  int                 sq_head;
  bit                 sq_any;

  // Idle and stall controls, changed by the stimulus process between phases.
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   rx_hold;
  bit   req_taken;
  event rx_hold_go;

  int mismatches;
  int n_sleeps, n_ticks, n_released, n_rejected, n_immediate, n_checked;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Link slot n into the list so that it wakes after `ticks` ticks. Entries
  // waking at the same tick keep their arrival order, so the walk only stops
  // in front of an entry that wakes strictly later.
  function automatic void link_sleeper(input int n, input logic [DELTA_W-1:0] ticks);
    logic [DELTA_W-1:0] rem;
    int                 cur;
    int                 nx;
    int                 steps;
    bit                 walking;
    rem = ticks;
    if (!sq_any) begin
      sq_delta[n] = rem;
      sq_tail[n]  = 1'b1;
      sq_head     = n;
      sq_any      = 1'b1;
    end else if (sq_delta[sq_head] > rem) begin
      // Strictly earlier than the head: the new entry becomes the head and
      // the old head keeps only the difference.
      sq_delta[sq_head] = sq_delta[sq_head] - rem;
      sq_delta[n]       = rem;
      sq_next[n]        = sq_head;
      sq_tail[n]        = 1'b0;
      sq_head           = n;
    end else begin
      rem     = rem - sq_delta[sq_head];
      cur     = sq_head;
      steps   = 0;
      walking = 1'b1;
      while (walking && steps < SLOTS && !sq_tail[cur]) begin
        nx = sq_next[cur];
        if (rem < sq_delta[nx]) begin
          walking = 1'b0;
        end else begin
          rem   = rem - sq_delta[nx];
          cur   = nx;
          steps = steps + 1;
        end
      end
      sq_delta[n] = rem;
      if (!sq_tail[cur]) begin
        nx           = sq_next[cur];
        sq_next[n]   = nx;
        sq_tail[n]   = 1'b0;
        sq_delta[nx] = sq_delta[nx] - rem;
      end else begin
        sq_tail[n] = 1'b1;
      end
      sq_next[cur] = n;
      sq_tail[cur] = 1'b0;
    end
  endfunction

  // Apply one accepted request to the shadow list. Returns 1 when the request
  // produces a result, which is then placed in res.
  function automatic bit predict_wakeup(input sleep_req_t req, output wake_res_t res);
    int slot;
    int h;
    res  = '0;
    slot = -1;
    if (req.op == OP_SLEEP) begin
      n_sleeps++;
      if (req.ms == '0) begin
        // Zero duration never touches the list, even when it is full.
        res.kind = KIND_READY;
        res.id   = req.pid;
        n_immediate++;
        return 1'b1;
      end
      for (int s = SLOTS - 1; s >= 0; s--)
        if (!sq_used[s]) slot = s;
      if (slot < 0) begin
        res.kind = KIND_REJECT;
        res.id   = req.pid;
        n_rejected++;
        return 1'b1;
      end
      sq_used[slot] = 1'b1;
      sq_pid[slot]  = req.pid;
      link_sleeper(slot, DELTA_W'(req.ms / 10));
      return 1'b0;
    end
    n_ticks++;
    if (!sq_any) return 1'b0;
    if (sq_delta[sq_head] != '0) begin
      sq_delta[sq_head] = sq_delta[sq_head] - 1'b1;
      return 1'b0;
    end
    // The head has run out: release exactly one process on this tick.
    h        = sq_head;
    res.kind = KIND_READY;
    res.id   = sq_pid[h];
    n_released++;
    sq_used[h] = 1'b0;
    if (sq_tail[h]) begin
      sq_any     = 1'b0;
      sq_tail[h] = 1'b0;
    end else begin
      sq_head = sq_next[h];
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the oldest queued request. Inputs change only at the
  // falling edge, so the block always sees settled values at the rising edge.
  // A request stays on the channel until it has been taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || req_taken)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        req_next        = req_backlog.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.op      <= req_next.op;
        req_ch.proc_id <= req_next.pid;
        req_ch.time_ms <= req_next.ms;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result-side flow control. A long hold-off, when requested, overrides the
  // random stalls so that results pile up and the block blocks its input.
  always @(negedge clk)
    wake_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

  always begin
    @(rx_hold_go);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard. Results are checked before the request of the
  // same edge is predicted; a result can never be caused by a request that is
  // accepted at the very same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    wake_res_t exp_res;
    wake_res_t got_res;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (wake_ch.valid && wake_ch.ready) begin
        got_res.kind = wake_ch.kind;
        got_res.id   = wake_ch.ready_id;
        n_checked++;
        if (wake_expect.size() == 0) begin
          $display("%0t: unexpected result transaction: kind %0d id 0x%02h",
                   $time, got_res.kind, got_res.id);
          mismatches++;
        end else begin
          exp_res = wake_expect.pop_front();
          if (got_res.kind !== exp_res.kind)  begin
            $display("%0t: kind mismatch: expected %0d, got %0d (id 0x%02h)",
                     $time, exp_res.kind, got_res.kind, exp_res.id);
            mismatches++;
          end
          if (got_res.id !== exp_res.id) begin
            $display("%0t: ready_id mismatch: expected 0x%02h, got 0x%02h",
                     $time, exp_res.id, got_res.id);
            mismatches++;
          end
        end
      end
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        req_next.op  = req_ch.op;
        req_next.pid = req_ch.proc_id;
        req_next.ms  = req_ch.time_ms;
        if (predict_wakeup(req_next, exp_res)) wake_expect.push_back(exp_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(input logic op, input logic [PID_W-1:0] pid,
                           input logic [MS_W-1:0] ms);
    sleep_req_t r;
    r.op  = op;
    r.pid = pid;
    r.ms  = ms;
    req_backlog.push_back(r);
  endtask

  // Mostly short sleeps so that entries keep draining, exact multiples of the
  // tick period to produce equal wake times, a few zero-duration requests, and
  // rarely a full-range duration that will stay in the list for good.
  task automatic queue_random_req(input int tick_pct);
    sleep_req_t r;
    int         pick;
    pick  = $urandom_range(999);
    r.op  = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_SLEEP;
    r.pid = ($urandom_range(3) == 0) ? PID_W'($urandom_range(7)) : PID_W'($urandom);
    if (r.op == OP_TICK)  r.ms = $urandom;
    else if (pick < 50)   r.ms = '0;
    else if (pick < 450)  r.ms = $urandom_range(99, 1);
    else if (pick < 800)  r.ms = $urandom_range(400, 100);
    else if (pick < 996)  r.ms = 10 * $urandom_range(30, 1);
    else                  r.ms = $urandom;
    req_backlog.push_back(r);
  endtask

  // Hold the sender back until everything queued has been taken and every
  // predicted result has come out.
  task automatic wait_drain();
    int guard;
    guard = 0;
    while (req_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (wake_expect.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (wake_expect.size() != 0) begin
      $display("%0t: %0d expected result transactions never arrived",
               $time, wake_expect.size());
      mismatches += wake_expect.size();
      wake_expect.delete();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int tx_mode[4];
    int rx_mode[4];
    tx_mode = '{0, 48, 0, 14};
    rx_mode = '{0, 0, 48, 14};

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_SLEEP;
    req_ch.proc_id = '0;
    req_ch.time_ms = '0;
    wake_ch.ready  = 1'b0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold        = 1'b0;
    req_taken      = 1'b0;
    mismatches     = 0;
    n_sleeps       = 0;
    n_ticks        = 0;
    n_released     = 0;
    n_rejected     = 0;
    n_immediate    = 0;
    n_checked      = 0;
    sq_head        = 0;
    sq_any         = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      sq_used[s] = 1'b0;
      sq_tail[s] = 1'b0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. A tick on the empty list must stay silent; then the
    // field extremes, the two largest durations (these stay in the list for
    // the whole run), sub-tick sleeps, a duplicate process, and equal wake
    // times that must come out in arrival order.
    queue_req(OP_TICK,  8'hFF, 32'hFFFF_FFFF);
    queue_req(OP_SLEEP, 8'h00, 32'h0000_0000);
    queue_req(OP_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    queue_req(OP_SLEEP, 8'h80, 32'h8000_0000);
    queue_req(OP_SLEEP, 8'h11, 32'd9);
    queue_req(OP_SLEEP, 8'h11, 32'd1);
    queue_req(OP_SLEEP, 8'h22, 32'd10);
    queue_req(OP_SLEEP, 8'h33, 32'd29);
    queue_req(OP_SLEEP, 8'h44, 32'd20);
    queue_req(OP_SLEEP, 8'h55, 32'd19);
    queue_req(OP_SLEEP, 8'h66, 32'd30);
    for (int i = 0; i < 10; i++) queue_req(OP_TICK, 8'h00, 32'h0);
    queue_req(OP_SLEEP, 8'h77, 32'd5);
    queue_req(OP_TICK,  8'h5A, 32'h0);
    wait_drain();

    // Fill the store with short sleeps well past its capacity, so the last
    // requests are turned away. The sender then pauses until those
    // rejections have been checked.
    for (int i = 0; i < 36; i++)
      queue_req(OP_SLEEP, PID_W'($urandom), $urandom_range(80, 1));
    wait_drain();

    // With the store full, stop taking results for a long stretch while
    // zero-duration requests, more rejections and enough ticks to empty the
    // short entries keep arriving: results back up and the input stalls.
    -> rx_hold_go;
    for (int i = 0; i < 3; i++) queue_req(OP_SLEEP, PID_W'($urandom), 32'h0);
    for (int i = 0; i < 3; i++) queue_req(OP_SLEEP, PID_W'($urandom), 32'd50);
    for (int i = 0; i < 45; i++) queue_req(OP_TICK, PID_W'($urandom), $urandom);
    wait_drain();

    // Random part: one phase for each mix of sender gaps and receiver stalls.
    // Phases with a lower tick share keep the list long and sometimes full.
    for (int m = 0; m < 4; m++) begin
      tx_idle_pct = tx_mode[m];
      rx_idle_pct = rx_mode[m];
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_req((m % 2 == 0) ? 50 : 44);
      wait_drain();
    end

    // Let a full list walk pass to catch any stray result after the last one.
    repeat (2 * SLOTS) @(posedge clk);

    $display("Run covered %0d sleep requests and %0d ticks; %0d results checked.",
             n_sleeps, n_ticks, n_checked);
    $display("Of those, %0d timed wake-ups, %0d zero-duration and %0d full-store cases.",
             n_released, n_immediate, n_rejected);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("%0t: timeout with %0d requests queued and %0d results outstanding",
             $time, req_backlog.size(), wake_expect.size());
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/dlsq_pkg.sv
design/dlsq_if.sv
design/dlsq_ctrl.sv
design/dlsq_dp.sv
design/delta_list_sleep_queue_core.sv
tb/tb.sv
